>>> sv/selt_pkg.sv
package selt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int KEY_BYTES   = 8;
   localparam int KEY_IN_W    = 64;
   localparam int KEY_W       = 8 * KEY_BYTES;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int QUOTA_W     = (CNT_W > 5) ? CNT_W : 5;
   localparam int LEVELS      = 4;

   // opcodes
   localparam logic [2:0] OP_TRY_LOCK  = 3'd0;
   localparam logic [2:0] OP_WAIT_LOCK = 3'd1;
   localparam logic [2:0] OP_REL_ONE   = 3'd2;
   localparam logic [2:0] OP_REL_OWNER = 3'd3;
   localparam logic [2:0] OP_ABORT     = 3'd4;

   // result status
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_REFUSED       = 3'd1;
   localparam logic [2:0] ST_WAIT_QUOTA    = 3'd2;
   localparam logic [2:0] ST_WAIT_CONFLICT = 3'd3;
   localparam logic [2:0] ST_NOT_HELD      = 3'd4;
   localparam logic [2:0] ST_BAD_FIELD     = 3'd5;
   localparam logic [2:0] ST_BAD_OPCODE    = 3'd6;

   // entry modes
   localparam logic [1:0] MODE_EXCL  = 2'd0;
   localparam logic [1:0] MODE_SHARE = 2'd1;
   localparam logic [1:0] MODE_EMPTY = 2'd3;

   // csr register indexes
   localparam int          CSR_ADDR_W = 4;
   localparam logic [1:0]  REG_QUOTA_ONE   = 2'd0;
   localparam logic [1:0]  REG_QUOTA_TWO   = 2'd1;
   localparam logic [1:0]  REG_QUOTA_THREE = 2'd2;

   // one table entry as stored in memory
   typedef struct packed {
      logic [1:0]       mode;
      logic [15:0]      owner;
      logic [1:0]       level;
      logic [KEY_W-1:0] key;
      logic             waiting;
   } entry_type;

endpackage

>>> sv/selt_if.sv
// request channel
interface selt_req_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    opcode;
   logic [15:0]                   owner;
   logic [2:0]                    lock_level;
   logic [1:0]                    lock_mode;
   logic [selt_pkg::KEY_IN_W-1:0] lock_key;

   modport source (output valid, opcode, owner, lock_level, lock_mode, lock_key,
                   input ready);
   modport sink   (input valid, opcode, owner, lock_level, lock_mode, lock_key,
                   output ready);
endinterface

// response channel
interface selt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [3:0] slot_index;
   logic [4:0] released_count;
   logic       woke_waiters;

   modport source (output valid, status, slot_index, released_count, woke_waiters,
                   input ready);
   modport sink   (input valid, status, slot_index, released_count, woke_waiters,
                   output ready);
endinterface

>>> sv/shared_exclusive_lock_table_top.sv
// channel   dir  handshake        word
// req_bus   in   valid/ready      opcode, owner, lock_level, lock_mode, lock_key
// rsp_bus   out  valid/ready      status, slot_index, released_count, woke_waiters
// csr_*     in   apb, pready = 1  quota_level_one/two/three at 0x0, 0x4, 0x8
//
// a table request runs from one accepted word to the next as: the accept cycle in idle, one
// pass over the entry memory with one read per cycle on its single read port, a drain of
// the pass, then the finish state, which loads the response register; no new word is
// accepted until then. bad field and bad opcode words skip the pass.
// reset is synchronous and clears the entry valid bits at once; no clearing pass.
// a finished word waits in the response register; a stalled response holds the finish.

module shared_exclusive_lock_table_top (
   input  logic                             clock,
   input  logic                             reset,
   selt_req_if.sink                         req_bus,
   selt_rsp_if.source                       rsp_bus,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [selt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   localparam int D  = selt_pkg::TABLE_DEPTH;
   localparam int IW = selt_pkg::IDX_W;
   localparam int CW = selt_pkg::CNT_W;
   localparam int QW = selt_pkg::QUOTA_W;
   localparam int KW = selt_pkg::KEY_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   // entry memory
   selt_pkg::entry_type mem [D];
   logic                mem_we;
   logic [IW-1:0]       mem_wa;
   selt_pkg::entry_type mem_wd;

   logic [1:0]          state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic                bad_ff, bad_in;
   logic [15:0]         owner_ff, owner_in;
   logic [2:0]          level_ff, level_in;
   logic [1:0]          mode_ff, mode_in;
   logic [KW-1:0]       key_ff, key_in;

   logic [CW-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                pv_ff, pv_in;
   logic [IW-1:0]       pidx_ff, pidx_in;
   selt_pkg::entry_type rd_word_ff;
   logic                rd_valid_ff;

   logic [D-1:0]        valid_ff, valid_in;
   logic [QW-1:0]       quota_ff [selt_pkg::LEVELS];
   logic [QW-1:0]       quota_in [selt_pkg::LEVELS];

   logic                cfl_found_ff, cfl_found_in;
   logic [IW-1:0]       cfl_idx_ff, cfl_idx_in;
   selt_pkg::entry_type cfl_word_ff, cfl_word_in;
   logic                emp_found_ff, emp_found_in;
   logic [IW-1:0]       emp_idx_ff, emp_idx_in;
   logic                hit_ff, hit_in;
   logic [IW-1:0]       hit_idx_ff, hit_idx_in;
   logic [CW-1:0]       rel_cnt_ff, rel_cnt_in;
   logic                woke_ff, woke_in;

   logic [4:0]          q1_ff, q2_ff, q3_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          status_ff, status_in;
   logic [3:0]          slot_ff, slot_in;
   logic [4:0]          relout_ff, relout_in;
   logic                wokeout_ff, wokeout_in;

   logic                csr_wr;

   // config registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_ff <= 5'd16;
         q2_ff <= 5'd16;
         q3_ff <= 5'd16;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            selt_pkg::REG_QUOTA_ONE:   q1_ff <= csr_pwdata[4:0];
            selt_pkg::REG_QUOTA_TWO:   q2_ff <= csr_pwdata[4:0];
            selt_pkg::REG_QUOTA_THREE: q3_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         selt_pkg::REG_QUOTA_ONE:   csr_prdata = 32'(q1_ff);
         selt_pkg::REG_QUOTA_TWO:   csr_prdata = 32'(q2_ff);
         selt_pkg::REG_QUOTA_THREE: csr_prdata = 32'(q3_ff);
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // handshakes
   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.slot_index     = slot_ff;
   assign rsp_bus.released_count = relout_ff;
   assign rsp_bus.woke_waiters   = wokeout_ff;

   // memory ports, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_word_ff  <= mem[rd_cnt_ff[IW-1:0]];
      rd_valid_ff <= valid_ff[rd_cnt_ff[IW-1:0]];
   end

   // sequencer and per-entry processing
   always_comb begin
      selt_pkg::entry_type w;
      logic occ, kl, do_free, blocked, out_free;
      int i;

      state_in     = state_ff;
      op_in        = op_ff;
      bad_in       = bad_ff;
      owner_in     = owner_ff;
      level_in     = level_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      rd_cnt_in    = rd_cnt_ff;
      pv_in        = 1'b0;
      pidx_in      = pidx_ff;
      valid_in     = valid_ff;
      quota_in     = quota_ff;
      cfl_found_in = cfl_found_ff;
      cfl_idx_in   = cfl_idx_ff;
      cfl_word_in  = cfl_word_ff;
      emp_found_in = emp_found_ff;
      emp_idx_in   = emp_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      rel_cnt_in   = rel_cnt_ff;
      woke_in      = woke_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      slot_in      = slot_ff;
      relout_in    = relout_ff;
      wokeout_in   = wokeout_ff;
      mem_we       = 1'b0;
      mem_wa       = pidx_ff;
      mem_wd       = rd_word_ff;

      w        = rd_word_ff;
      occ      = rd_valid_ff && (w.mode != selt_pkg::MODE_EMPTY);
      kl       = occ && (w.key == key_ff) && ({1'b0, w.level} == level_ff);
      do_free  = 1'b0;
      out_free = !rsp_valid_ff || rsp_bus.ready;
      blocked  = 1'b0;
      for (i = 0; i < selt_pkg::LEVELS; i++) begin
         if (i <= int'(level_ff) && quota_ff[i] == '0) begin
            blocked = 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in        = req_bus.opcode;
               owner_in     = req_bus.owner;
               level_in     = req_bus.lock_level;
               mode_in      = req_bus.lock_mode;
               key_in       = req_bus.lock_key[KW-1:0];
               bad_in       = (req_bus.opcode == selt_pkg::OP_TRY_LOCK ||
                               req_bus.opcode == selt_pkg::OP_WAIT_LOCK) &&
                              (req_bus.lock_level > 3'd3 ||
                               req_bus.lock_mode > selt_pkg::MODE_SHARE);
               rd_cnt_in    = '0;
               cfl_found_in = 1'b0;
               emp_found_in = 1'b0;
               hit_in       = 1'b0;
               rel_cnt_in   = '0;
               woke_in      = 1'b0;
               if (bad_in || req_bus.opcode > selt_pkg::OP_ABORT) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // issue the next read
            if (rd_cnt_ff != CW'(D)) begin
               pv_in     = 1'b1;
               pidx_in   = rd_cnt_ff[IW-1:0];
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end else if (!pv_ff) begin
               state_in = S_DONE;
            end
            // look at the word read last cycle
            if (pv_ff) begin
               case (op_ff)
                  selt_pkg::OP_TRY_LOCK, selt_pkg::OP_WAIT_LOCK: begin
                     if (kl && (w.mode == selt_pkg::MODE_EXCL ||
                                mode_ff == selt_pkg::MODE_EXCL) && !cfl_found_ff) begin
                        cfl_found_in = 1'b1;
                        cfl_idx_in   = pidx_ff;
                        cfl_word_in  = w;
                     end
                     if (!occ && !emp_found_ff) begin
                        emp_found_in = 1'b1;
                        emp_idx_in   = pidx_ff;
                     end
                  end
                  selt_pkg::OP_REL_ONE: begin
                     if (kl && w.owner == owner_ff && !hit_ff) begin
                        do_free    = 1'b1;
                        hit_in     = 1'b1;
                        hit_idx_in = pidx_ff;
                     end
                  end
                  selt_pkg::OP_REL_OWNER: begin
                     do_free = occ && (w.owner == owner_ff);
                  end
                  selt_pkg::OP_ABORT: begin
                     if (occ) begin
                        rel_cnt_in = rel_cnt_ff + 1'b1;
                     end
                     if (rd_valid_ff && w.waiting) begin
                        woke_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
               // free one entry and give its quota back
               if (do_free) begin
                  mem_we        = 1'b1;
                  mem_wa        = pidx_ff;
                  mem_wd        = w;
                  mem_wd.mode   = selt_pkg::MODE_EMPTY;
                  mem_wd.owner  = '0;
                  mem_wd.waiting = 1'b0;
                  rel_cnt_in    = rel_cnt_ff + 1'b1;
                  if (w.waiting) begin
                     woke_in = 1'b1;
                  end
                  for (i = 0; i < selt_pkg::LEVELS; i++) begin
                     if (i <= int'(w.level)) begin
                        quota_in[i] = quota_ff[i] + 1'b1;
                        if (quota_in[i] == QW'(1)) begin
                           woke_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = selt_pkg::ST_OK;
               slot_in      = '0;
               relout_in    = '0;
               wokeout_in   = 1'b0;
               if (bad_ff) begin
                  status_in = selt_pkg::ST_BAD_FIELD;
               end else begin
                  case (op_ff)
                     selt_pkg::OP_TRY_LOCK, selt_pkg::OP_WAIT_LOCK: begin
                        if (blocked) begin
                           status_in = (op_ff == selt_pkg::OP_TRY_LOCK) ?
                                       selt_pkg::ST_REFUSED : selt_pkg::ST_WAIT_QUOTA;
                        end else if (cfl_found_ff) begin
                           if (op_ff == selt_pkg::OP_TRY_LOCK) begin
                              status_in = selt_pkg::ST_REFUSED;
                           end else begin
                              // mark the conflicting entry as waited on
                              mem_we         = 1'b1;
                              mem_wa         = cfl_idx_ff;
                              mem_wd         = cfl_word_ff;
                              mem_wd.waiting = 1'b1;
                              status_in      = selt_pkg::ST_WAIT_CONFLICT;
                              slot_in        = 4'(cfl_idx_ff);
                           end
                        end else if (emp_found_ff) begin
                           // grant into the first empty slot
                           mem_we         = 1'b1;
                           mem_wa         = emp_idx_ff;
                           mem_wd.mode    = mode_ff;
                           mem_wd.owner   = owner_ff;
                           mem_wd.level   = level_ff[1:0];
                           mem_wd.key     = key_ff;
                           mem_wd.waiting = 1'b0;
                           valid_in[emp_idx_ff] = 1'b1;
                           slot_in        = 4'(emp_idx_ff);
                           for (i = 0; i < selt_pkg::LEVELS; i++) begin
                              if (i <= int'(level_ff)) begin
                                 quota_in[i] = quota_ff[i] - 1'b1;
                              end
                           end
                        end else begin
                           status_in = (op_ff == selt_pkg::OP_TRY_LOCK) ?
                                       selt_pkg::ST_REFUSED : selt_pkg::ST_WAIT_QUOTA;
                        end
                     end
                     selt_pkg::OP_REL_ONE: begin
                        status_in  = hit_ff ? selt_pkg::ST_OK : selt_pkg::ST_NOT_HELD;
                        slot_in    = hit_ff ? 4'(hit_idx_ff) : 4'd0;
                        relout_in  = 5'(rel_cnt_ff);
                        wokeout_in = woke_ff;
                     end
                     selt_pkg::OP_REL_OWNER: begin
                        relout_in  = 5'(rel_cnt_ff);
                        wokeout_in = woke_ff;
                     end
                     selt_pkg::OP_ABORT: begin
                        relout_in  = 5'(rel_cnt_ff);
                        wokeout_in = woke_ff ||
                                     (quota_ff[0] == '0) ||
                                     (quota_ff[1] == '0 && q1_ff != 5'd0) ||
                                     (quota_ff[2] == '0 && q2_ff != 5'd0) ||
                                     (quota_ff[3] == '0 && q3_ff != 5'd0);
                        valid_in    = '0;
                        quota_in[0] = QW'(D);
                        quota_in[1] = QW'(q1_ff);
                        quota_in[2] = QW'(q2_ff);
                        quota_in[3] = QW'(q3_ff);
                     end
                     default: begin
                        status_in = selt_pkg::ST_BAD_OPCODE;
                     end
                  endcase
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         quota_ff[0]  <= QW'(D);
         quota_ff[1]  <= QW'(5'd16);
         quota_ff[2]  <= QW'(5'd16);
         quota_ff[3]  <= QW'(5'd16);
      end else begin
         state_ff     <= state_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         quota_ff     <= quota_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      bad_ff       <= bad_in;
      owner_ff     <= owner_in;
      level_ff     <= level_in;
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      rd_cnt_ff    <= rd_cnt_in;
      pidx_ff      <= pidx_in;
      cfl_found_ff <= cfl_found_in;
      cfl_idx_ff   <= cfl_idx_in;
      cfl_word_ff  <= cfl_word_in;
      emp_found_ff <= emp_found_in;
      emp_idx_ff   <= emp_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      rel_cnt_ff   <= rel_cnt_in;
      woke_ff      <= woke_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
      relout_ff    <= relout_in;
      wokeout_ff   <= wokeout_in;
   end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
   import selt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] owner;
      logic [2:0]  level;
      logic [1:0]  mode;
      logic [63:0] key;
   } lock_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot;
      logic [4:0] released;
      logic       woke;
   } lock_rsp_type;

   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 30;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   selt_req_if req_bus ();
   selt_rsp_if rsp_bus ();

   shared_exclusive_lock_table_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow copy of the lock table
   logic [1:0]  shadow_mode [TABLE_DEPTH];
   logic [15:0] shadow_owner [TABLE_DEPTH];
   logic [1:0]  shadow_level [TABLE_DEPTH];
   logic [63:0] shadow_key [TABLE_DEPTH];
   logic        shadow_waiting [TABLE_DEPTH];
   int          quota_left [LEVELS];
   int          quota_cfg [LEVELS];

   lock_rsp_type pending_rsp [$];
   bit        failed = 1'b0;
   int        req_idle_pct;
   int        rsp_idle_pct;
   logic [63:0] key_pool [4];
   logic [15:0] owner_pool [4];

   function automatic logic [63:0] key_mask();
      if (KEY_W >= 64) return '1;
      return (64'd1 << KEY_W) - 64'd1;
   endfunction

   function automatic void clear_shadow();
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         shadow_mode[k] = MODE_EMPTY;
         shadow_owner[k] = '0;
         shadow_level[k] = '0;
         shadow_key[k] = '0;
         shadow_waiting[k] = 1'b0;
      end
      quota_left[0] = TABLE_DEPTH;
      for (int i = 1; i < LEVELS; i++) quota_left[i] = quota_cfg[i];
   endfunction

   function automatic bit quota_exhausted(int lvl);
      for (int i = 0; i <= lvl && i < LEVELS; i++)
         if (quota_left[i] == 0) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int conflict_slot(int lvl, logic [1:0] md, logic [63:0] key);
      for (int k = 0; k < TABLE_DEPTH; k++)
         if (shadow_mode[k] != MODE_EMPTY && shadow_key[k] == key &&
             shadow_level[k] == lvl && (shadow_mode[k] == MODE_EXCL || md == MODE_EXCL))
            return k;
      return -1;
   endfunction

   function automatic int grant_slot(lock_req_type r, logic [63:0] key);
      for (int k = 0; k < TABLE_DEPTH; k++)
         if (shadow_mode[k] == MODE_EMPTY) begin
            shadow_owner[k] = r.owner;
            shadow_level[k] = r.level[1:0];
            shadow_mode[k] = r.mode;
            shadow_key[k] = key;
            for (int i = 0; i <= r.level && i < LEVELS; i++) quota_left[i]--;
            return k;
         end
      return -1;
   endfunction

   function automatic bit free_entry(int k, logic [15:0] own, inout bit woke);
      if (shadow_mode[k] == MODE_EMPTY || shadow_owner[k] != own) return 1'b0;
      shadow_mode[k] = MODE_EMPTY;
      shadow_owner[k] = '0;
      if (shadow_waiting[k]) begin
         shadow_waiting[k] = 1'b0;
         woke = 1'b1;
      end
      for (int i = 0; i <= shadow_level[k] && i < LEVELS; i++) begin
         quota_left[i]++;
         if (quota_left[i] == 1) woke = 1'b1;
      end
      return 1'b1;
   endfunction

   // computes the response of one word and updates the shadow table
   function automatic lock_rsp_type lock_outcome(lock_req_type r);
      lock_rsp_type o;
      logic [63:0] key;
      int          k;
      int          c;
      int          rel;
      bit          woke;
      key = r.key & key_mask();
      o = '0;
      rel = 0;
      woke = 1'b0;
      if ((r.op == OP_TRY_LOCK || r.op == OP_WAIT_LOCK) &&
          (r.level > 3 || r.mode > MODE_SHARE)) begin
         o.status = ST_BAD_FIELD;
      end else if (r.op == OP_TRY_LOCK) begin
         if (quota_exhausted(r.level) || conflict_slot(r.level, r.mode, key) >= 0) begin
            o.status = ST_REFUSED;
         end else begin
            k = grant_slot(r, key);
            if (k < 0) o.status = ST_REFUSED;
            else o.slot = k[3:0];
         end
      end else if (r.op == OP_WAIT_LOCK) begin
         c = conflict_slot(r.level, r.mode, key);
         if (quota_exhausted(r.level)) begin
            o.status = ST_WAIT_QUOTA;
         end else if (c >= 0) begin
            shadow_waiting[c] = 1'b1;
            o.status = ST_WAIT_CONFLICT;
            o.slot = c[3:0];
         end else begin
            k = grant_slot(r, key);
            if (k < 0) o.status = ST_WAIT_QUOTA;
            else o.slot = k[3:0];
         end
      end else if (r.op == OP_REL_ONE) begin
         o.status = ST_NOT_HELD;
         for (k = 0; k < TABLE_DEPTH; k++)
            if (shadow_mode[k] != MODE_EMPTY && shadow_key[k] == key &&
                shadow_level[k] == r.level && shadow_owner[k] == r.owner) begin
               void'(free_entry(k, r.owner, woke));
               o.status = ST_OK;
               o.slot = k[3:0];
               rel = 1;
               break;
            end
      end else if (r.op == OP_REL_OWNER) begin
         for (k = 0; k < TABLE_DEPTH; k++)
            if (free_entry(k, r.owner, woke)) rel++;
      end else if (r.op == OP_ABORT) begin
         for (k = 0; k < TABLE_DEPTH; k++) begin
            if (shadow_mode[k] != MODE_EMPTY) rel++;
            if (shadow_waiting[k]) woke = 1'b1;
         end
         if (quota_left[0] == 0) woke = 1'b1;
         for (int i = 1; i < LEVELS; i++)
            if (quota_left[i] == 0 && quota_cfg[i] != 0) woke = 1'b1;
         clear_shadow();
      end else begin
         o.status = ST_BAD_OPCODE;
      end
      o.released = rel[4:0];
      o.woke = woke;
      return o;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response ready with random stalls
   always @(posedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);

   // compare each response word against the oldest prediction
   always @(posedge clock) begin
      lock_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response status %0d", $time, rsp_bus.status);
            failed = 1'b1;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_bus.status);
               failed = 1'b1;
            end
            if (rsp_bus.slot_index !== want.slot) begin
               $display("%0t: slot_index expected %0d actual %0d",
                        $time, want.slot, rsp_bus.slot_index);
               failed = 1'b1;
            end
            if (rsp_bus.released_count !== want.released) begin
               $display("%0t: released_count expected %0d actual %0d",
                        $time, want.released, rsp_bus.released_count);
               failed = 1'b1;
            end
            if (rsp_bus.woke_waiters !== want.woke) begin
               $display("%0t: woke_waiters expected %0d actual %0d",
                        $time, want.woke, rsp_bus.woke_waiters);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles with no accepted word
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // send one request word, predicting at acceptance
   task automatic send_lock_req(lock_req_type r);
      if ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= r.op;
      req_bus.owner <= r.owner;
      req_bus.lock_level <= r.level;
      req_bus.lock_mode <= r.mode;
      req_bus.lock_key <= r.key;
      do @(posedge clock); while (!req_bus.ready);
      pending_rsp.push_back(lock_outcome(r));
   endtask

   task automatic send_fields(logic [2:0] op, logic [15:0] own, logic [2:0] lvl,
                              logic [1:0] md, logic [63:0] key);
      lock_req_type r;
      r = '{op: op, owner: own, level: lvl, mode: md, key: key};
      send_lock_req(r);
   endtask

   // wait until every response has come back and the block is idle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      quota_cfg[idx + 1] = value & 31;
   endtask

   task automatic set_quotas(int q1, int q2, int q3);
      wait_idle();
      csr_write(REG_QUOTA_ONE, q1);
      csr_write(REG_QUOTA_TWO, q2);
      csr_write(REG_QUOTA_THREE, q3);
   endtask

   // field extremes, conflicts, waiting, releases, bad fields and opcodes
   task automatic test_directed();
      send_fields(OP_TRY_LOCK, 16'h0000, 3'd0, MODE_EXCL, 64'd0);
      send_fields(OP_TRY_LOCK, 16'hffff, 3'd0, MODE_SHARE, 64'd0);
      send_fields(OP_WAIT_LOCK, 16'hffff, 3'd0, MODE_SHARE, 64'd0);
      send_fields(OP_TRY_LOCK, 16'hffff, 3'd3, MODE_SHARE, '1);
      send_fields(OP_TRY_LOCK, 16'h0001, 3'd3, MODE_SHARE, '1);
      send_fields(OP_TRY_LOCK, 16'h0001, 3'd3, MODE_EXCL, '1);
      send_fields(OP_TRY_LOCK, 16'h0001, 3'd4, MODE_EXCL, 64'd5);
      send_fields(OP_TRY_LOCK, 16'h0001, 3'd7, MODE_SHARE, 64'd5);
      send_fields(OP_TRY_LOCK, 16'h0001, 3'd1, 2'd2, 64'd5);
      send_fields(OP_WAIT_LOCK, 16'h0001, 3'd2, 2'd3, 64'd5);
      send_fields(3'd5, 16'h0001, 3'd7, 2'd3, 64'd5);
      send_fields(3'd6, 16'h0001, 3'd0, MODE_EXCL, 64'd5);
      send_fields(3'd7, 16'hffff, 3'd1, MODE_SHARE, '1);
      send_fields(OP_REL_ONE, 16'h0005, 3'd0, MODE_EXCL, 64'd0);
      send_fields(OP_REL_ONE, 16'h0000, 3'd7, MODE_EXCL, 64'd0);
      send_fields(OP_REL_ONE, 16'h0000, 3'd0, MODE_EXCL, 64'd0);
      send_fields(OP_REL_OWNER, 16'hffff, 3'd0, MODE_EXCL, 64'd0);
      send_fields(OP_REL_OWNER, 16'h1234, 3'd0, MODE_EXCL, 64'd0);
      send_fields(OP_WAIT_LOCK, 16'h0002, 3'd2, MODE_EXCL, 64'h8000_0000_0000_0001);
      send_fields(OP_ABORT, 16'h0000, 3'd0, MODE_EXCL, 64'd0);
   endtask

   // exhausted and minimal quotas, wakeup on a counter rising from zero
   task automatic test_quota_limits();
      set_quotas(0, 0, 0);
      send_fields(OP_ABORT, 16'h0000, 3'd0, MODE_EXCL, 64'd0);
      send_fields(OP_TRY_LOCK, 16'h0003, 3'd1, MODE_EXCL, 64'd9);
      send_fields(OP_WAIT_LOCK, 16'h0003, 3'd2, MODE_EXCL, 64'd9);
      send_fields(OP_TRY_LOCK, 16'h0003, 3'd0, MODE_EXCL, 64'd9);
      set_quotas(1, 1, 1);
      send_fields(OP_ABORT, 16'h0000, 3'd0, MODE_EXCL, 64'd0);
      send_fields(OP_TRY_LOCK, 16'h0004, 3'd3, MODE_SHARE, 64'd7);
      send_fields(OP_WAIT_LOCK, 16'h0004, 3'd1, MODE_SHARE, 64'd8);
      send_fields(OP_REL_ONE, 16'h0004, 3'd3, MODE_SHARE, 64'd7);
      send_fields(OP_TRY_LOCK, 16'h0004, 3'd3, MODE_SHARE, 64'd7);
      send_fields(OP_ABORT, 16'h0000, 3'd0, MODE_EXCL, 64'd0);
   endtask

   function automatic lock_req_type random_req();
      lock_req_type r;
      int        pick;
      int        k;
      r.owner = ($urandom_range(9) == 0) ? 16'($urandom) : owner_pool[$urandom_range(3)];
      r.key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(3)];
      r.level = 3'($urandom_range(3));
      r.mode = 2'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 35) r.op = OP_TRY_LOCK;
      else if (pick < 55) r.op = OP_WAIT_LOCK;
      else if (pick < 75) r.op = OP_REL_ONE;
      else if (pick < 85) r.op = OP_REL_OWNER;
      else if (pick < 88) r.op = OP_ABORT;
      else if (pick < 95) begin
         // lock request with a bad level or mode
         r.op = 3'($urandom_range(1));
         if ($urandom_range(1)) r.level = 3'($urandom_range(7, 4));
         else r.mode = 2'($urandom_range(3, 2));
      end else begin
         r.op = 3'($urandom_range(7, 5));
         r.level = 3'($urandom);
         r.mode = 2'($urandom);
      end
      // most single releases, and half of owner releases, try to name a held lock
      if (r.op == OP_REL_ONE && $urandom_range(9) < 7) begin
         k = $urandom_range(TABLE_DEPTH - 1);
         if (shadow_mode[k] != MODE_EMPTY) begin
            r.owner = shadow_owner[k];
            r.level = {1'b0, shadow_level[k]};
            r.key = shadow_key[k];
         end
      end
      if (r.op == OP_REL_OWNER && $urandom_range(1)) begin
         k = $urandom_range(TABLE_DEPTH - 1);
         if (shadow_mode[k] != MODE_EMPTY) r.owner = shadow_owner[k];
      end
      return r;
   endfunction

   // random traffic over several quota settings and idling profiles
   task automatic test_random_traffic();
      int q [6][3];
      q = '{'{16, 16, 16}, '{0, 3, 16}, '{2, 2, 1}, '{16, 0, 0}, '{5, 9, 12}, '{1, 16, 4}};
      for (int seg = 0; seg < 6; seg++) begin
         set_quotas(q[seg][0], q[seg][1], q[seg][2]);
         case (seg / 2)
            0: begin
               req_idle_pct = 26;
               rsp_idle_pct = 81;
            end
            1: begin
               req_idle_pct = 81;
               rsp_idle_pct = 26;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         send_fields(OP_ABORT, 16'h0000, 3'd0, MODE_EXCL, 64'd0);
         repeat (115) send_lock_req(random_req());
      end
   endtask

   initial begin
      req_idle_pct = 26;
      rsp_idle_pct = 81;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.owner = '0;
      req_bus.lock_level = '0;
      req_bus.lock_mode = '0;
      req_bus.lock_key = '0;
      for (int i = 1; i < LEVELS; i++) quota_cfg[i] = 16;
      clear_shadow();
      key_pool = '{64'd0, '1, {$urandom, $urandom}, {$urandom, $urandom}};
      owner_pool = '{16'h0000, 16'hffff, 16'($urandom), 16'($urandom)};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_quota_limits();
      test_random_traffic();
      wait_idle();

      if (!failed)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> shared_exclusive_lock_table_top.f
sv/selt_pkg.sv
sv/selt_if.sv
sv/shared_exclusive_lock_table_top.sv
tb/sv/tb_top.sv
